[rtl/core/desa_pkg.sv]
// ----------------------------------------------------------------------------
// desa_pkg: shared types and constants of the double-ended stack allocator
// Field widths, action and status codes, controller/datapath signal groups.
// ----------------------------------------------------------------------------
package desa_pkg;

   // field widths
   localparam int FIELD_W  = 24;
   localparam int ACTION_W = 2;
   localparam int STATUS_W = 3;

   // defaults of the top level parameters
   localparam int MARK_DEPTH_DEF  = 16;
   localparam int ALIGN_BYTES_DEF = 8;
   localparam int ADDR_BITS_DEF   = 24;

   // heap size after reset
   localparam logic [FIELD_W-1:0] HEAP_RESET = 24'd1048576;

   // request actions
   localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MARK    = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOMEM = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   // controller -> datapath commands
   typedef struct packed {
      logic take_req;   // latch request word
      logic take_cfg;   // latch heap size word
      logic mul;        // reciprocal multiply
      logic qmul;       // quotient times alignment
      logic fix;        // correction, aligned size ready
      logic init;       // reload pointers, empty stacks
      logic read;       // mark stack read
      logic exec;       // apply action, form result
      logic load;       // move result into output register
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic req_align;    // incoming request is a nonzero allocate
      logic req_release;  // incoming request is a release
      logic cfg_op;       // alignment run belongs to a heap size write
      logic out_free;     // output register can take a word
   } sts_type;

endpackage

[rtl/core/desa_ifs.sv]
// ----------------------------------------------------------------------------
// desa channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------

// request channel
interface desa_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [desa_pkg::ACTION_W-1:0]         action;
   logic                                  from_top;
   logic [desa_pkg::FIELD_W-1:0]          request_bytes;

   modport source (output valid, action, from_top, request_bytes, input ready);
   modport sink   (input valid, action, from_top, request_bytes, output ready);
endinterface

// response channel
interface desa_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [desa_pkg::FIELD_W-1:0]          address;
   logic [desa_pkg::STATUS_W-1:0]         status;

   modport source (output valid, address, status, input ready);
   modport sink   (input valid, address, status, output ready);
endinterface

// heap size register write channel
interface desa_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [desa_pkg::FIELD_W-1:0]          heap_size;

   modport source (output valid, heap_size, input ready);
   modport sink   (input valid, heap_size, output ready);
endinterface

[rtl/core/double_ended_stack_allocator_core.sv]
// ----------------------------------------------------------------------------
// double_ended_stack_allocator_core: two-ended mark/release heap allocator
// Allocates from the bottom or top end of one heap, with per-end mark stacks.
// ----------------------------------------------------------------------------
// Channels: req_port takes one request word (action, from_top, request_bytes),
// rsp_port returns exactly one word (address, status) per request, csr_port
// writes heap_size, which reloads both pointers and empties both mark stacks.
// One request is in work at a time. After acceptance, mark, unused actions and
// zero-size allocates pass the execute and load states; a release first does
// one registered mark stack read, and any other allocate first runs the align-up
// chain (reciprocal multiply, quotient times alignment, correction). The next
// request is taken in idle after its predecessor's word is loaded, if no heap
// size write wins. A heap size write runs the align-up chain, then the reload.
// The response sits in an output register: while the receiver stalls, the
// block accepts and works the next request and holds its word until the
// register frees. After reset the heap is 1048576 bytes, the bottom pointer
// is 0, the top pointer the aligned heap size, and both mark stacks are empty.
// ----------------------------------------------------------------------------
module double_ended_stack_allocator_core #(
   parameter int MARK_DEPTH  = desa_pkg::MARK_DEPTH_DEF,
   parameter int ALIGN_BYTES = desa_pkg::ALIGN_BYTES_DEF,
   parameter int ADDR_BITS   = desa_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   desa_req_if.sink    req_port,
   desa_rsp_if.source  rsp_port,
   desa_csr_if.sink    csr_port
);

   desa_pkg::cmd_type cmd;
   desa_pkg::sts_type sts;

   // sequencer
   desa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .csr_valid (csr_port.valid),
      .csr_ready (csr_port.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath
   desa_dpath #(
      .MARK_DEPTH  (MARK_DEPTH),
      .ALIGN_BYTES (ALIGN_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_port.action),
      .req_from_top      (req_port.from_top),
      .req_request_bytes (req_port.request_bytes),
      .csr_heap_size     (csr_port.heap_size),
      .rsp_valid         (rsp_port.valid),
      .rsp_ready         (rsp_port.ready),
      .rsp_address       (rsp_port.address),
      .rsp_status        (rsp_port.status)
   );

endmodule

[rtl/core/desa_ctrl.sv]
// ----------------------------------------------------------------------------
// desa_ctrl: allocator sequencer
// Steps one request or one heap size write through the datapath.
// ----------------------------------------------------------------------------
module desa_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  desa_pkg::sts_type  sts,
   output desa_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_MUL  = 3'd1;
   localparam logic [2:0] S_QMUL = 3'd2;
   localparam logic [2:0] S_FIX  = 3'd3;
   localparam logic [2:0] S_INIT = 3'd4;
   localparam logic [2:0] S_READ = 3'd5;
   localparam logic [2:0] S_EXEC = 3'd6;
   localparam logic [2:0] S_LOAD = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // register writes win over requests in idle
   assign csr_ready = (state_ff == S_IDLE);
   assign req_ready = (state_ff == S_IDLE) & ~csr_valid;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               cmd.take_cfg = 1'b1;
               state_in     = S_MUL;
            end else if (req_valid) begin
               cmd.take_req = 1'b1;
               if (sts.req_align)        state_in = S_MUL;
               else if (sts.req_release) state_in = S_READ;
               else                      state_in = S_EXEC;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_QMUL;
         end
         S_QMUL: begin
            cmd.qmul = 1'b1;
            state_in = S_FIX;
         end
         S_FIX: begin
            cmd.fix  = 1'b1;
            state_in = sts.cfg_op ? S_INIT : S_EXEC;
         end
         S_INIT: begin
            cmd.init = 1'b1;
            state_in = S_IDLE;
         end
         S_READ: begin
            cmd.read = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            if (sts.out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/desa_dpath.sv]
// ----------------------------------------------------------------------------
// desa_dpath: allocator datapath
// Size alignment unit, both end pointers, both mark stacks, output register.
// ----------------------------------------------------------------------------
module desa_dpath #(
   parameter int MARK_DEPTH  = desa_pkg::MARK_DEPTH_DEF,
   parameter int ALIGN_BYTES = desa_pkg::ALIGN_BYTES_DEF,
   parameter int ADDR_BITS   = desa_pkg::ADDR_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  desa_pkg::cmd_type                  cmd,
   output desa_pkg::sts_type                  sts,
   input  logic [desa_pkg::ACTION_W-1:0]      req_action,
   input  logic                               req_from_top,
   input  logic [desa_pkg::FIELD_W-1:0]       req_request_bytes,
   input  logic [desa_pkg::FIELD_W-1:0]       csr_heap_size,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [desa_pkg::FIELD_W-1:0]       rsp_address,
   output logic [desa_pkg::STATUS_W-1:0]      rsp_status
);

   // alignment operand width: a field plus the rounding carry
   localparam int SW   = desa_pkg::FIELD_W + 1;
   localparam int RW   = SW + 1;
   localparam int CW   = (ADDR_BITS > SW) ? ADDR_BITS : SW;
   localparam int CNTW = $clog2(MARK_DEPTH + 1);
   localparam int IW   = (MARK_DEPTH > 1) ? $clog2(MARK_DEPTH) : 1;

   localparam logic [RW-1:0] RECIP     = RW'((64'd1 << SW) / ALIGN_BYTES);
   localparam logic [SW-1:0] ALIGN_W   = SW'(ALIGN_BYTES);
   localparam logic [SW-1:0] ALIGN_M1  = SW'(ALIGN_BYTES - 1);
   localparam logic [63:0]   ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
   localparam logic [63:0]   TOP_MAX   = (ADDR_MASK / ALIGN_BYTES) * ALIGN_BYTES;
   localparam logic [63:0]   HEAP_ALN  =
      ((64'(desa_pkg::HEAP_RESET) + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
   localparam logic [63:0]   TOP_RESET = (HEAP_ALN > ADDR_MASK) ? TOP_MAX : HEAP_ALN;
   localparam logic [CNTW-1:0] DEPTH_C = CNTW'(MARK_DEPTH);

   // request and alignment registers
   logic [desa_pkg::ACTION_W-1:0] act_ff;
   logic                          top_sel_ff;
   logic                          zero_ff;
   logic                          cfg_ff;
   logic [SW-1:0]                 m_ff;
   logic [SW+RW-1:0]              prod_ff;
   logic [SW-1:0]                 qa_ff;
   logic [SW-1:0]                 size_ff;
   logic [SW-1:0]                 diff;

   // allocator state
   logic [ADDR_BITS-1:0] top_ff,  top_in;
   logic [ADDR_BITS-1:0] bot_ff,  bot_in;
   logic [CNTW-1:0]      tcnt_ff, tcnt_in;
   logic [CNTW-1:0]      bcnt_ff, bcnt_in;
   logic [ADDR_BITS-1:0] top_marks [MARK_DEPTH];
   logic [ADDR_BITS-1:0] bot_marks [MARK_DEPTH];
   logic [ADDR_BITS-1:0] trd_ff;
   logic [ADDR_BITS-1:0] brd_ff;
   logic [IW-1:0]        tidx;
   logic [IW-1:0]        bidx;
   logic                 push_top;
   logic                 push_bot;

   // result and output registers
   logic [desa_pkg::FIELD_W-1:0]  res_addr_ff,   res_addr_in;
   logic [desa_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic                          rsp_valid_ff;
   logic [desa_pkg::FIELD_W-1:0]  rsp_addr_ff;
   logic [desa_pkg::STATUS_W-1:0] rsp_status_ff;

   // execute-stage arithmetic in a common width
   logic [CW-1:0]        size_c, top_c, bot_c, room;
   logic [ADDR_BITS-1:0] top_sub, bot_add, top_init;

   // status to controller
   assign sts.req_align   = (req_action == desa_pkg::ACT_ALLOC) &&
                            (req_request_bytes != '0);
   assign sts.req_release = (req_action == desa_pkg::ACT_RELEASE);
   assign sts.cfg_op      = cfg_ff;
   assign sts.out_free    = ~rsp_valid_ff | rsp_ready;

   // align-up unit: floor((n+A-1)/A)*A by reciprocal, one correction step
   assign diff = m_ff - qa_ff;

   always_ff @(posedge clock) begin
      if (cmd.take_req) begin
         act_ff     <= req_action;
         top_sel_ff <= req_from_top;
         zero_ff    <= (req_request_bytes == '0);
         m_ff       <= SW'(req_request_bytes) + ALIGN_M1;
      end else if (cmd.take_cfg) begin
         m_ff       <= SW'(csr_heap_size) + ALIGN_M1;
      end
      if (cmd.mul)  prod_ff <= (SW+RW)'(m_ff) * (SW+RW)'(RECIP);
      if (cmd.qmul) qa_ff   <= prod_ff[SW +: SW] * ALIGN_W;
      if (cmd.fix)  size_ff <= (diff >= ALIGN_W) ? (qa_ff + ALIGN_W) : qa_ff;
   end

   // heap size write flag: set by a register write, cleared by a request
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= 1'b0;
      end else if (cmd.take_cfg) begin
         cfg_ff <= 1'b1;
      end else if (cmd.take_req) begin
         cfg_ff <= 1'b0;
      end
   end

   // mark stack read, top of each stack
   assign tidx = (tcnt_ff == '0) ? '0 : IW'(tcnt_ff - CNTW'(1));
   assign bidx = (bcnt_ff == '0) ? '0 : IW'(bcnt_ff - CNTW'(1));

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         trd_ff <= top_marks[tidx];
         brd_ff <= bot_marks[bidx];
      end
   end

   // mark stack push
   always_ff @(posedge clock) begin
      if (push_top) top_marks[IW'(tcnt_ff)] <= top_ff;
      if (push_bot) bot_marks[IW'(bcnt_ff)] <= bot_ff;
   end

   assign size_c   = CW'(size_ff);
   assign top_c    = CW'(top_ff);
   assign bot_c    = CW'(bot_ff);
   assign room     = (top_c >= bot_c) ? (top_c - bot_c) : '0;
   assign top_sub  = ADDR_BITS'(top_c - size_c);
   assign bot_add  = ADDR_BITS'(bot_c + size_c);
   assign top_init = (CW'(size_ff) > CW'(ADDR_MASK)) ? TOP_MAX[ADDR_BITS-1:0]
                                                     : ADDR_BITS'(size_ff);

   // pointer, stack and result update
   always_comb begin
      top_in        = top_ff;
      bot_in        = bot_ff;
      tcnt_in       = tcnt_ff;
      bcnt_in       = bcnt_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      push_top      = 1'b0;
      push_bot      = 1'b0;
      if (cmd.init) begin
         top_in  = top_init;
         bot_in  = '0;
         tcnt_in = '0;
         bcnt_in = '0;
      end
      if (cmd.exec) begin
         res_addr_in   = '0;
         res_status_in = desa_pkg::ST_OK;
         unique case (act_ff)
            desa_pkg::ACT_ALLOC: begin
               if (zero_ff) begin
                  res_status_in = desa_pkg::ST_ZERO;
               end else if (size_c > room) begin
                  res_status_in = desa_pkg::ST_NOMEM;
               end else if (top_sel_ff) begin
                  top_in      = top_sub;
                  res_addr_in = desa_pkg::FIELD_W'(top_sub);
               end else begin
                  bot_in      = bot_add;
                  res_addr_in = desa_pkg::FIELD_W'(bot_ff);
               end
            end
            desa_pkg::ACT_MARK: begin
               if (top_sel_ff) begin
                  if (tcnt_ff >= DEPTH_C) begin
                     res_status_in = desa_pkg::ST_FULL;
                  end else begin
                     push_top = 1'b1;
                     tcnt_in  = tcnt_ff + CNTW'(1);
                  end
               end else begin
                  if (bcnt_ff >= DEPTH_C) begin
                     res_status_in = desa_pkg::ST_FULL;
                  end else begin
                     push_bot = 1'b1;
                     bcnt_in  = bcnt_ff + CNTW'(1);
                  end
               end
            end
            desa_pkg::ACT_RELEASE: begin
               if (top_sel_ff) begin
                  if (tcnt_ff == '0) begin
                     res_status_in = desa_pkg::ST_EMPTY;
                  end else begin
                     top_in  = trd_ff;
                     tcnt_in = tcnt_ff - CNTW'(1);
                  end
               end else begin
                  if (bcnt_ff == '0) begin
                     res_status_in = desa_pkg::ST_EMPTY;
                  end else begin
                     bot_in  = brd_ff;
                     bcnt_in = bcnt_ff - CNTW'(1);
                  end
               end
            end
            default: ;  // unused action code: no effect, answers ok
         endcase
      end
   end

   // allocator state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff  <= TOP_RESET[ADDR_BITS-1:0];
         bot_ff  <= '0;
         tcnt_ff <= '0;
         bcnt_ff <= '0;
      end else begin
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         tcnt_ff <= tcnt_in;
         bcnt_ff <= bcnt_in;
      end
   end

   // result holding register
   always_ff @(posedge clock) begin
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_address = rsp_addr_ff;
   assign rsp_status  = rsp_status_ff;

endmodule
